// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the peak detector, clocked on
// clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define WPD_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define WPD_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/wpd_pkg.sv =====
// ----------------------------------------------------------------------------
// Waveform peak detector package
// Widths, register indexes and the beat types shared by the detector modules.
// ----------------------------------------------------------------------------
package wpd_pkg;

  localparam int unsigned SampleW    = 16;
  localparam int unsigned MaxRecLen  = 4096;
  localparam int unsigned IdxW       = $clog2(MaxRecLen);
  localparam int unsigned WidthW     = $clog2(MaxRecLen + 1);
  localparam logic [IdxW-1:0] IdxMax = IdxW'(MaxRecLen - 1);

  localparam logic signed [SampleW-1:0] HeightThrReset = 16'sd4;
  localparam logic [WidthW-1:0]         WidthThrReset  = '0;

  typedef enum logic [0:0] {
    RegHeightThr = 1'b0,
    RegWidthThr  = 1'b1
  } wpd_reg_e;

  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic                      last_sample;
  } wpd_beat_t;

  typedef struct packed {
    logic [IdxW-1:0]           peak_position;
    logic signed [SampleW-1:0] peak_height;
    logic [WidthW-1:0]         peak_width;
  } wpd_peak_t;

endpackage

// ===== design/wpd_stream_if.sv =====
// ----------------------------------------------------------------------------
// Peak detector stream interfaces
// Valid/ready channels for sample beats in and peak beats out.
// ----------------------------------------------------------------------------
interface wpd_sample_if;
  logic                               valid;
  logic                               ready;
  logic signed [wpd_pkg::SampleW-1:0] sample;
  logic                               last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink (input valid, input sample, input last_sample, output ready);
endinterface

interface wpd_peak_if;
  logic                               valid;
  logic                               ready;
  logic [wpd_pkg::IdxW-1:0]           peak_position;
  logic signed [wpd_pkg::SampleW-1:0] peak_height;
  logic [wpd_pkg::WidthW-1:0]         peak_width;

  modport source (output valid, output peak_position, output peak_height,
                  output peak_width, input ready);
  modport sink (input valid, input peak_position, input peak_height,
                input peak_width, output ready);
endinterface

// ===== design/wpd_in_stage.sv =====
// ----------------------------------------------------------------------------
// Peak detector input register
// Captures one sample beat and holds it until the detector core takes it.
// ----------------------------------------------------------------------------
module wpd_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  wpd_sample_if.sink         in_sample,
  output logic               s1_valid_o,
  output wpd_pkg::wpd_beat_t s1_beat_o,
  input  logic               s1_ready_i
);

  logic               valid_q;
  wpd_pkg::wpd_beat_t beat_q;
  logic               take;

  assign in_sample.ready = !valid_q || s1_ready_i;
  assign take            = in_sample.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= in_sample.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && in_sample.valid) begin
      beat_q.sample      <= in_sample.sample;
      beat_q.last_sample <= in_sample.last_sample;
    end
  end

  assign s1_valid_o = valid_q;
  assign s1_beat_o  = beat_q;

endmodule

// ===== design/wpd_core.sv =====
// ----------------------------------------------------------------------------
// Peak detector core
// Holds the thresholds and the per-record run state, and decides for each
// sample beat whether a peak closes and passes both thresholds.
// ----------------------------------------------------------------------------
module wpd_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  wpd_pkg::wpd_reg_e            cfg_index_i,
  input  logic [wpd_pkg::SampleW-1:0]  cfg_data_i,
  input  logic                         s1_valid_i,
  input  wpd_pkg::wpd_beat_t           s1_beat_i,
  input  logic                         out_free_i,
  output logic                         fire_o,
  output logic                         res_valid_o,
  output wpd_pkg::wpd_peak_t           res_o
);

  logic signed [wpd_pkg::SampleW-1:0] height_thr_q;
  logic [wpd_pkg::WidthW-1:0]         width_thr_q;

  logic signed [wpd_pkg::SampleW-1:0] prev_value_q;
  logic                               prev_rising_q;
  logic [wpd_pkg::IdxW-1:0]           idx_q;
  logic [wpd_pkg::IdxW-1:0]           rise_start_q;
  logic                               pend_q;
  logic [wpd_pkg::IdxW-1:0]           pend_pos_q;
  logic signed [wpd_pkg::SampleW-1:0] pend_height_q;
  logic [wpd_pkg::IdxW-1:0]           pend_left_q;

  logic                               fire;
  logic                               first;
  logic                               last;
  logic signed [wpd_pkg::SampleW-1:0] v;
  logic                               rising;
  logic                               falling;
  logic [wpd_pkg::IdxW-1:0]           kprev;
  logic                               close_pend;
  logic                               close_new;
  logic                               open_pend;
  logic [wpd_pkg::IdxW-1:0]           sel_pos;
  logic signed [wpd_pkg::SampleW-1:0] sel_height;
  logic [wpd_pkg::IdxW-1:0]           sel_left;
  logic [wpd_pkg::IdxW-1:0]           sel_right;
  logic [wpd_pkg::WidthW-1:0]         width;

  assign fire    = s1_valid_i && out_free_i;
  assign v       = s1_beat_i.sample;
  assign last    = s1_beat_i.last_sample;
  assign first   = (idx_q == '0);
  assign rising  = v > prev_value_q;
  assign falling = prev_value_q > v;
  assign kprev   = idx_q - wpd_pkg::IdxW'(1);

  assign close_pend = !first && pend_q && (!falling || last);
  assign close_new  = !first && prev_rising_q && falling && last;
  assign open_pend  = !first && prev_rising_q && falling && !last;

  always_comb begin
    if (pend_q) begin
      sel_pos    = pend_pos_q;
      sel_height = pend_height_q;
      sel_left   = pend_left_q;
      sel_right  = falling ? idx_q : kprev;
    end else begin
      sel_pos    = kprev;
      sel_height = prev_value_q;
      sel_left   = rise_start_q;
      sel_right  = idx_q;
    end
    if (sel_right >= sel_left) begin
      width = {1'b0, sel_right} - {1'b0, sel_left} + wpd_pkg::WidthW'(1);
    end else begin
      width = wpd_pkg::WidthW'(1);
    end
  end

  assign fire_o      = fire;
  assign res_valid_o = fire && (close_pend || close_new) &&
                       (sel_height >= height_thr_q) && (width >= width_thr_q);
  assign res_o.peak_position = sel_pos;
  assign res_o.peak_height   = sel_height;
  assign res_o.peak_width    = width;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_thr_q <= wpd_pkg::HeightThrReset;
      width_thr_q  <= wpd_pkg::WidthThrReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        wpd_pkg::RegHeightThr: height_thr_q <= cfg_data_i;
        wpd_pkg::RegWidthThr:  width_thr_q  <= cfg_data_i[wpd_pkg::WidthW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_value_q  <= '0;
      prev_rising_q <= 1'b0;
      idx_q         <= '0;
      rise_start_q  <= '0;
      pend_q        <= 1'b0;
      pend_pos_q    <= '0;
      pend_height_q <= '0;
      pend_left_q   <= '0;
    end else if (fire) begin
      prev_value_q <= v;
      if (last) begin
        idx_q         <= '0;
        prev_rising_q <= 1'b0;
        rise_start_q  <= '0;
        pend_q        <= 1'b0;
      end else begin
        if (idx_q < wpd_pkg::IdxMax) begin
          idx_q <= idx_q + wpd_pkg::IdxW'(1);
        end
        if (first) begin
          prev_rising_q <= 1'b0;
          rise_start_q  <= '0;
          pend_q        <= 1'b0;
        end else begin
          prev_rising_q <= rising;
          if (rising && !prev_rising_q) begin
            rise_start_q <= kprev;
          end
          if (open_pend) begin
            pend_q        <= 1'b1;
            pend_pos_q    <= kprev;
            pend_height_q <= prev_value_q;
            pend_left_q   <= rise_start_q;
          end else if (close_pend) begin
            pend_q <= 1'b0;
          end
        end
      end
    end
  end

endmodule

// ===== design/wpd_out_stage.sv =====
// ----------------------------------------------------------------------------
// Peak detector result register
// Holds one peak beat until the downstream side takes it.
// ----------------------------------------------------------------------------
module wpd_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               res_valid_i,
  input  wpd_pkg::wpd_peak_t res_i,
  output logic               free_o,
  wpd_peak_if.source         out_peak
);

  logic               valid_q;
  wpd_pkg::wpd_peak_t res_q;

  assign free_o = !valid_q || out_peak.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (res_valid_i) begin
      valid_q <= 1'b1;
    end else if (out_peak.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_peak.valid         = valid_q;
  assign out_peak.peak_position = res_q.peak_position;
  assign out_peak.peak_height   = res_q.peak_height;
  assign out_peak.peak_width    = res_q.peak_width;

endmodule

// ===== design/waveform_peak_detector_unit.sv =====
// ----------------------------------------------------------------------------
// Waveform peak detector
// Streaming local-maximum detector that reports position, height and width
// of each peak once its right edge is known and both thresholds are met.
// ----------------------------------------------------------------------------
//  Channel     Direction  Beat contents
//  in_sample   sink       sample, last_sample
//  out_peak    source     peak_position, peak_height, peak_width
//  cfg         write      cfg_we_i, cfg_index_i, cfg_data_i
//
//  One sample beat is taken every cycle while the input register is not held
//  back; an accepted sample passes through the input register, the single
//  compare stage and the result register before its peak beat appears.
//  Reset clears the thresholds to their defaults and the record state.
//  A stalled result register holds back the input register, and input
//  stalls only while both are full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module waveform_peak_detector_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  wpd_pkg::wpd_reg_e           cfg_index_i,
  input  logic [wpd_pkg::SampleW-1:0] cfg_data_i,
  wpd_sample_if.sink                  in_sample,
  wpd_peak_if.source                  out_peak
);

  logic               s1_valid;
  wpd_pkg::wpd_beat_t s1_beat;
  logic               out_free;
  logic               fire;
  logic               res_valid;
  wpd_pkg::wpd_peak_t res;
  logic               width_in_range;

  wpd_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_sample  (in_sample),
    .s1_valid_o (s1_valid),
    .s1_beat_o  (s1_beat),
    .s1_ready_i (out_free)
  );

  wpd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .s1_valid_i  (s1_valid),
    .s1_beat_i   (s1_beat),
    .out_free_i  (out_free),
    .fire_o      (fire),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  wpd_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .free_o      (out_free),
    .out_peak    (out_peak)
  );

  assign width_in_range = (out_peak.peak_width != '0) &&
                          (out_peak.peak_width <= wpd_pkg::WidthW'(wpd_pkg::MaxRecLen));

  `WPD_ASSERT_NOW(a_width_range, out_peak.valid, width_in_range)
  `WPD_ASSERT_NOW(a_result_needs_fire, res_valid, fire)
  `WPD_ASSERT_NEXT(a_stage_holds, s1_valid && !out_free, s1_valid && $stable(s1_beat))
  `WPD_ASSERT_NEXT(a_no_spurious_peak, !out_peak.valid && !res_valid, !out_peak.valid)

endmodule
